// ----- src/array_list_engine_defines.svh -----
// Assertion macros shared by the array list engine RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALE_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ale_pkg.sv -----
// Shared types and constants for the array list engine.
// Depends on nothing; used by the interfaces, array_list_engine and the testbench.
package ale_pkg;

  // Fixed field widths of the input and result words.
  localparam int MODE_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 6;
  localparam int POS_W     = 6;
  localparam int LEN_OUT_W = 7;

  // A find-all operation reports at most this many matches.
  localparam int RESULT_LIMIT = 64;
  localparam int CNT_W        = $clog2(RESULT_LIMIT);

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_POP         = 3'd1,
    OP_REMOVE_AT   = 3'd2,
    OP_FIND_ALL    = 3'd3,
    OP_FIND_REMOVE = 3'd4
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FIND_END,
    ST_EMIT
  } state_t;

  // One result record, without the length.
  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] pos;
    logic             last;
  } res_t;

endpackage

// ----- src/ale_if.sv -----
// Valid/ready channel interfaces for the array list engine input and result words.
// Depends on ale_pkg for the field widths.
interface ale_in_if;
  import ale_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, mode, value, index, input ready);
  modport sink   (input valid, mode, value, index, output ready);
endinterface

interface ale_out_if;
  import ale_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [POS_W-1:0]     position;
  logic                 last;
  logic [LEN_OUT_W-1:0] length_after;

  modport source (output valid, ok, position, last, length_after, input ready);
  modport sink   (input valid, ok, position, last, length_after, output ready);
endinterface

// ----- src/ale_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; instanced for the list storage.
module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/array_list_engine.sv -----
// Top level of the array list engine: controller, length register and result register.
// Depends on ale_pkg, ale_if.sv, ale_ram and array_list_engine_defines.svh.
//
//   Channel   Dir  Handshake               Word fields
//   in_chan   in   valid/ready             mode, value, index
//   out_chan  out  valid/ready             ok, position, last, length_after
//
// One operation at a time; in_chan.ready is high only while idle. Append, remove-last, failed
// remove-at and unused codes go straight to the emit state. Remove-at shifts the later entries
// down one place; find-all and find-and-remove scan from the start, and find-and-remove then
// shifts the entries after its match. Each further find-all match releases the one held before.
// One RAM read and one RAM write per cycle bound the scans and shifts.
// Reset clears the length and control state only; a waiting result holds the emit state.
`include "array_list_engine_defines.svh"

module array_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ale_in_if.sink    in_chan,
  ale_out_if.source out_chan
);
  import ale_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;

  state_t               state_r, state_nxt;
  state_t               ret_r, ret_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  res_t                 res_r, res_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [AW-1:0]        pend_pos_r, pend_pos_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic [LEN_OUT_W-1:0] out_len_r, out_len_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic          in_acc;
  logic          out_free;
  logic          rd_more;
  logic          hit;
  logic          walk_done;
  logic          idx_ok;
  logic          len_room;
  logic          last_slot;
  logic [CW-1:0] idx_c;
  logic [CW-1:0] len_c;

  // List storage.
  ale_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and status terms.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign rd_more       = (rd_ptr_r < len_r);
  assign hit           = cmp_v_r && (ram_rdata == val_r);
  assign walk_done     = !rd_more && !cmp_v_r;
  assign idx_c         = CW'(in_chan.index);
  assign len_c         = CW'(len_r);
  assign idx_ok        = (idx_c < len_c);
  assign len_room      = (len_r < LW'(DEPTH));
  assign last_slot     = (cnt_r == CNT_W'(RESULT_LIMIT - 2));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_chan.mode)
            OP_REMOVE_AT:                state_nxt = idx_ok ? ST_SHIFT : ST_EMIT;
            OP_FIND_ALL, OP_FIND_REMOVE: state_nxt = ST_SCAN;
            default:                     state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        priority if (hit && (mode_r == OP_FIND_REMOVE)) begin
          state_nxt = ST_SHIFT;
        end else if (hit && pend_v_r) begin
          state_nxt = ST_EMIT;
        end else if (walk_done) begin
          state_nxt = ST_FIND_END;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SHIFT: begin
        if (walk_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_FIND_END: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory access and result logic.
  always_comb begin
    ret_nxt       = ret_r;
    len_nxt       = len_r;
    rd_ptr_nxt    = rd_ptr_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_v_nxt     = cmp_v_r;
    mode_nxt      = mode_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    pend_v_nxt    = pend_v_r;
    pend_pos_nxt  = pend_pos_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_res_nxt   = out_res_r;
    out_len_nxt   = out_len_r;
    ram_we        = 1'b0;
    ram_waddr     = cmp_idx_r - AW'(1);
    ram_wdata     = ram_rdata;
    ram_raddr     = rd_ptr_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_chan.mode;
          val_nxt  = in_chan.value;
          res_nxt  = '{ok: 1'b0, pos: '0, last: 1'b1};
          ret_nxt  = ST_IDLE;
          unique case (in_chan.mode)
            OP_APPEND: begin
              if (len_room) begin
                ram_we     = 1'b1;
                ram_waddr  = len_r[AW-1:0];
                ram_wdata  = in_chan.value;
                len_nxt    = len_r + LW'(1);
                res_nxt.ok = 1'b1;
              end
            end
            OP_POP: begin
              if (len_r != '0) begin
                len_nxt    = len_r - LW'(1);
                res_nxt.ok = 1'b1;
              end
            end
            OP_REMOVE_AT: begin
              if (idx_ok) begin
                res_nxt.ok = 1'b1;
                rd_ptr_nxt = LW'(idx_c + CW'(1));
                cmp_v_nxt  = 1'b0;
              end
            end
            OP_FIND_ALL, OP_FIND_REMOVE: begin
              rd_ptr_nxt = '0;
              cmp_v_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              cnt_nxt    = '0;
            end
            default: begin
              // Unused codes report a failure and leave the list alone.
            end
          endcase
        end
      end

      // Read one entry a cycle until a match calls for a result; compare the word read in the cycle before.
      ST_SCAN: begin
        cmp_v_nxt   = rd_more;
        cmp_idx_nxt = rd_ptr_r[AW-1:0];
        if (rd_more) begin
          rd_ptr_nxt = rd_ptr_r + LW'(1);
        end
        if (hit) begin
          priority if (mode_r == OP_FIND_REMOVE) begin
            res_nxt    = '{ok: 1'b1, pos: POS_W'(cmp_idx_r), last: 1'b1};
            rd_ptr_nxt = LW'(cmp_idx_r) + LW'(1);
            cmp_v_nxt  = 1'b0;
            ret_nxt    = ST_IDLE;
          end else if (pend_v_r) begin
            // Release the held match; the new one waits for the next or the end.
            res_nxt      = '{ok: 1'b1, pos: POS_W'(pend_pos_r), last: 1'b0};
            pend_pos_nxt = cmp_idx_r;
            cnt_nxt      = cnt_r + CNT_W'(1);
            rd_ptr_nxt   = LW'(cmp_idx_r) + LW'(1);
            cmp_v_nxt    = 1'b0;
            ret_nxt      = last_slot ? ST_FIND_END : ST_SCAN;
          end else begin
            pend_v_nxt   = 1'b1;
            pend_pos_nxt = cmp_idx_r;
          end
        end
      end

      // Move entries down one place: read the source, then write it one lower in the cycle after.
      ST_SHIFT: begin
        cmp_v_nxt   = rd_more;
        cmp_idx_nxt = rd_ptr_r[AW-1:0];
        ret_nxt     = ST_IDLE;
        if (rd_more) begin
          rd_ptr_nxt = rd_ptr_r + LW'(1);
        end
        if (cmp_v_r) begin
          ram_we = 1'b1;
        end
        if (walk_done) begin
          len_nxt = len_r - LW'(1);
        end
      end

      // Final result of a find: the held match, or a miss.
      ST_FIND_END: begin
        ret_nxt = ST_IDLE;
        if (pend_v_r) begin
          res_nxt = '{ok: 1'b1, pos: POS_W'(pend_pos_r), last: 1'b1};
        end else begin
          res_nxt = '{ok: 1'b0, pos: '0, last: 1'b1};
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_len_nxt   = LEN_OUT_W'(len_r);
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      len_r       <= '0;
      cmp_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      len_r       <= len_nxt;
      cmp_v_r     <= cmp_v_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    mode_r     <= mode_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
    pend_pos_r <= pend_pos_nxt;
    out_res_r  <= out_res_nxt;
    out_len_r  <= out_len_nxt;
  end

  // Result channel.
  assign out_chan.valid        = out_valid_r;
  assign out_chan.ok           = out_res_r.ok;
  assign out_chan.position     = out_res_r.pos;
  assign out_chan.last         = out_res_r.last;
  assign out_chan.length_after = out_len_r;

  // Checks on the controller.
  `ALE_ASSERT_SAME(a_len_bound, clk, rst_n, 1'b1, len_r <= LW'(DEPTH), "length beyond depth")
  `ALE_ASSERT_NEXT(a_len_step, clk, rst_n, 1'b1, (len_r == $past(len_r)) || (len_r == $past(len_r) + LW'(1)) || (len_r == $past(len_r) - LW'(1)), "length moved by more than one")
  `ALE_ASSERT_SAME(a_mid_find, clk, rst_n, out_chan.valid && !out_chan.last, mode_r == OP_FIND_ALL, "non-final result outside find-all")
  `ALE_ASSERT_SAME(a_write_state, clk, rst_n, ram_we, (state_r == ST_IDLE) || (state_r == ST_SHIFT), "storage written outside append or shift")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for array_list_engine: drives operation words into the block,
// predicts every result word from its own copy of the list, and compares them in order.
// Depends on ale_pkg and the ale_in_if / ale_out_if channel interfaces of the RTL.
module tb_top;
  import ale_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int IDLE_PCT     = 27;
  localparam int POOL_SIZE    = 8;
  localparam int MIXED_ITEMS  = 150;
  localparam int RANDOM_ITEMS = 420;
  localparam int SETTLE_CYCLES = 4 * LIST_DEPTH;
  localparam longint WATCHDOG  = 3_000_000;

  // Mode codes that the block leaves unused.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                 ok;
    logic [POS_W-1:0]     position;
    logic                 last;
    logic [LEN_OUT_W-1:0] length_after;
  } result_word_t;

  // Tracks the list contents and holds the result words still owed by the block.
  class list_scoreboard;
    logic [VALUE_W-1:0] slots [LIST_DEPTH];
    int unsigned        count;
    result_word_t       owed_q[$];
    int unsigned        errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void owe(logic ok, int unsigned pos, logic last);
      result_word_t w;
      w.ok           = ok;
      w.position     = POS_W'(pos);
      w.last         = last;
      w.length_after = LEN_OUT_W'(count);
      owed_q.push_back(w);
    endfunction

    // Close the gap at pos by moving every later entry down one place.
    function void drop_slot(int unsigned pos);
      for (int unsigned j = pos; j + 1 < count; j++) begin
        slots[j] = slots[j + 1];
      end
      count--;
    endfunction

    // Apply one accepted operation word and queue the results it must cause.
    function void note_accepted(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                logic [INDEX_W-1:0] index);
      int unsigned hits;
      bit          found;
      hits  = 0;
      found = 0;
      case (mode)
        OP_APPEND: begin
          if (count < LIST_DEPTH) begin
            slots[count] = value;
            count++;
            owe(1'b1, 0, 1'b1);
          end else begin
            owe(1'b0, 0, 1'b1);
          end
        end
        OP_POP: begin
          if (count > 0) begin
            count--;
            owe(1'b1, 0, 1'b1);
          end else begin
            owe(1'b0, 0, 1'b1);
          end
        end
        OP_REMOVE_AT: begin
          if (index < count) begin
            drop_slot(index);
            owe(1'b1, 0, 1'b1);
          end else begin
            owe(1'b0, 0, 1'b1);
          end
        end
        OP_FIND_ALL: begin
          for (int unsigned i = 0; i < count && hits < RESULT_LIMIT; i++) begin
            if (slots[i] == value) begin
              owe(1'b1, i, 1'b0);
              hits++;
            end
          end
          if (hits == 0) begin
            owe(1'b0, 0, 1'b1);
          end else begin
            owed_q[owed_q.size() - 1].last = 1'b1;
          end
        end
        OP_FIND_REMOVE: begin
          for (int unsigned i = 0; i < count && !found; i++) begin
            if (slots[i] == value) begin
              drop_slot(i);
              owe(1'b1, i, 1'b1);
              found = 1;
            end
          end
          if (!found) begin
            owe(1'b0, 0, 1'b1);
          end
        end
        default: begin
          owe(1'b0, 0, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("tb_top: mismatch: %s", what);
      errors++;
    endtask

    // Compare one accepted result word with the oldest one owed.
    task check_result(result_word_t got);
      result_word_t exp;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word ok=%0b pos=%0d last=%0b len=%0d",
                                  got.ok, got.position, got.last, got.length_after));
      end else begin
        exp = owed_q.pop_front();
        if (got.ok !== exp.ok || got.position !== exp.position ||
            got.last !== exp.last || got.length_after !== exp.length_after) begin
          report_mismatch($sformatf("got ok=%0b pos=%0d last=%0b len=%0d, want %0b %0d %0b %0d",
                                    got.ok, got.position, got.last, got.length_after,
                                    exp.ok, exp.position, exp.last, exp.length_after));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int unsigned items_sent;
  int unsigned directed_done;
  logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];
  list_scoreboard sb = new();

  ale_in_if  in_if();
  ale_out_if out_if();

  array_list_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random back-pressure while idling is on.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= (idle_on && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
    end
  end

  // Check every result word at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result({out_if.ok, out_if.position, out_if.last, out_if.length_after});
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #(WATCHDOG);
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

  // Offer one word, with a random gap first, and wait until it is accepted.
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.value <= value;
    in_if.index <= index;
    do @(posedge clk); while (!in_if.ready);
    sb.note_accepted(mode, value, index);
    items_sent++;
  endtask

  // Hold the input off until every owed result has arrived.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.owed_q.size() != 0);
  endtask

  // Mostly words from a small pool, so that searches hit.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 80) begin
      return value_pool[$urandom_range(POOL_SIZE - 1)];
    end
    return $urandom;
  endfunction

  // Mostly an index inside the list, sometimes anywhere in the field.
  function automatic logic [INDEX_W-1:0] pick_index();
    if (sb.count != 0 && $urandom_range(99) < 75) begin
      return INDEX_W'($urandom_range(sb.count - 1));
    end
    return INDEX_W'($urandom_range(LIST_DEPTH - 1));
  endfunction

  task automatic send_random_item();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      send_word(OP_APPEND, pick_value(), pick_index());
    end else if (roll < 45) begin
      send_word(OP_POP, pick_value(), pick_index());
    end else if (roll < 60) begin
      send_word(OP_REMOVE_AT, pick_value(), pick_index());
    end else if (roll < 78) begin
      send_word(OP_FIND_ALL, pick_value(), pick_index());
    end else if (roll < 95) begin
      send_word(OP_FIND_REMOVE, pick_value(), pick_index());
    end else begin
      send_word(MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), pick_value(),
                pick_index());
    end
  endtask

  // Main sequence: reset, directed words, then random phases.
  initial begin
    logic signed [VALUE_W-1:0] fill_a;
    logic signed [VALUE_W-1:0] fill_b;

    rst_n        = 1'b0;
    idle_on      = 1'b1;
    items_sent   = 0;
    in_if.valid  = 1'b0;
    in_if.mode   = OP_APPEND;
    in_if.value  = '0;
    in_if.index  = '0;
    value_pool[0] = VALUE_MIN;
    value_pool[1] = VALUE_MAX;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) begin
      value_pool[i] = $urandom;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Pop, remove-at and both searches fail on an empty list.
    send_word(OP_POP, VALUE_MAX, '0);
    send_word(OP_REMOVE_AT, '0, '0);
    send_word(OP_FIND_ALL, '0, '0);
    send_word(OP_FIND_REMOVE, VALUE_MIN, '0);

    // Extreme words, with a repeat so that a search finds two places.
    send_word(OP_APPEND, VALUE_MIN, '1);
    send_word(OP_APPEND, VALUE_MAX, '0);
    send_word(OP_APPEND, '0, '0);
    send_word(OP_APPEND, -1, '0);
    send_word(OP_APPEND, VALUE_MIN, '0);
    send_word(OP_FIND_ALL, VALUE_MIN, '1);
    send_word(OP_FIND_ALL, 32'sd12345, '0);

    // Removal past the end, a shift, and search-and-remove.
    send_word(OP_REMOVE_AT, '0, '1);
    send_word(OP_REMOVE_AT, '0, 6'd5);
    send_word(OP_REMOVE_AT, '0, 6'd1);
    send_word(OP_FIND_ALL, VALUE_MIN, '0);
    send_word(OP_FIND_REMOVE, -1, '0);
    send_word(OP_FIND_REMOVE, 32'sd777, '0);
    send_word(OP_POP, '0, '0);

    // Unused mode codes are answered with a failed word.
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      send_word(MODE_W'(m), VALUE_MAX, '1);
    end
    directed_done = items_sent;

    // Mixed random operations with idling on both sides.
    repeat (MIXED_ITEMS) send_random_item();
    wait_drained();

    // No idling: fill the list with one word, search it, then with two words.
    idle_on <= 1'b0;
    while (sb.count != 0) send_word(OP_POP, pick_value(), pick_index());
    fill_a = pick_value();
    fill_b = $urandom;
    while (sb.count < LIST_DEPTH) send_word(OP_APPEND, fill_a, pick_index());
    send_word(OP_APPEND, VALUE_MAX, '0);
    send_word(OP_FIND_ALL, fill_a, '0);
    send_word(OP_REMOVE_AT, '0, '1);
    send_word(OP_FIND_REMOVE, fill_a, '0);
    while (sb.count != 0) send_word(OP_REMOVE_AT, '0, pick_index());
    while (sb.count < LIST_DEPTH) begin
      send_word(OP_APPEND, ($urandom_range(1) != 0) ? fill_a : fill_b, pick_index());
    end
    send_word(OP_APPEND, fill_b, '0);
    send_word(OP_FIND_ALL, fill_a, '0);
    send_word(OP_FIND_ALL, fill_b, '0);
    send_word(OP_REMOVE_AT, '0, 6'd31);
    send_word(OP_FIND_REMOVE, fill_b, '0);
    send_word(OP_FIND_ALL, fill_b, '0);
    idle_on <= 1'b1;

    // Random operations until the random part reaches its size.
    while (items_sent - directed_done < RANDOM_ITEMS) send_random_item();

    // Let every owed result arrive, then watch for strays.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/ale_pkg.sv
src/ale_if.sv
src/ale_ram.sv
src/array_list_engine.sv
tb/sv/tb_top.sv
